[hw/rtl/erss_pkg.sv]
// ----------------------------------------------------------------------------
// erss_pkg
// Shared constants for the earliest arrival route search core: field widths,
// result status codes and command codes.
// ----------------------------------------------------------------------------
package erss_pkg;

    localparam int PortW = 8;
    localparam int TimeW = 32;
    localparam int StatW = 3;

    typedef logic [StatW-1:0] t_status;

    localparam t_status ST_STORED  = 3'd0;
    localparam t_status ST_FOUND   = 3'd1;
    localparam t_status ST_UNKNOWN = 3'd2;
    localparam t_status ST_NOROUTE = 3'd3;
    localparam t_status ST_FULL    = 3'd4;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

endpackage

[hw/rtl/erss_ram.sv]
// ----------------------------------------------------------------------------
// erss_ram
// Generic single write port, single read port RAM with a registered read.
// ----------------------------------------------------------------------------
module erss_ram #(
    parameter int Width = 32,
    parameter int Depth = 256
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] i_waddr,
    input  logic [Width-1:0]                      i_wdata,
    input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] i_raddr,
    output logic [Width-1:0]                      o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[hw/rtl/earliest_arrival_route_search_core.sv]
// ----------------------------------------------------------------------------
// earliest_arrival_route_search_core
// Stores timed links and answers earliest arrival queries by repeated
// relaxation passes over the link table.
//
// Channel | Direction | Handshake                 | Payload
// in      | input     | i_in_valid / o_in_ready   | command, ports, times
// out     | output    | o_out_valid / i_out_ready | arrival_time, status
//
// A query steps each stored link through S_RL, S_LS, S_LD and S_UP in each
// pass, passes repeat until one changes no label, then S_FIN and S_RES read
// out the result; the link RAM and label RAM each have one read port.
// Reset clears the link count, port known bits and the output valid.
// A new beat is taken while the previous result waits on the out channel;
// the block stalls only when a finished result finds the output occupied.
// ----------------------------------------------------------------------------
module earliest_arrival_route_search_core #(
    parameter int MAX_PORTS = 256,
    parameter int MAX_LINKS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_command,
    input  logic [7:0]  i_source_port,
    input  logic [7:0]  i_dest_port,
    input  logic [31:0] i_depart_time,
    input  logic [31:0] i_arrive_time,
    input  logic [31:0] i_start_time,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_arrival_time,
    output logic [2:0]  o_status
);
    localparam int NumPorts = (MAX_PORTS < 256) ? MAX_PORTS : 256;
    localparam int PW = $clog2(NumPorts);
    localparam int LW = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
    localparam int CW = $clog2(MAX_LINKS + 1);
    localparam int LinkW = 2 * erss_pkg::PortW + 2 * erss_pkg::TimeW;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RL   = 3'd1;
    localparam logic [2:0] S_LS   = 3'd2;
    localparam logic [2:0] S_LD   = 3'd3;
    localparam logic [2:0] S_UP   = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;
    localparam logic [2:0] S_RES  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0]          r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_idx, n_idx;
    logic                r_changed, n_changed;
    logic                r_use, n_use;
    logic [NumPorts-1:0] r_known, n_known;
    logic [NumPorts-1:0] r_lvalid, n_lvalid;
    logic [PW-1:0]       r_qdst, n_qdst;
    logic [31:0]         r_res_arr, n_res_arr;
    erss_pkg::t_status   r_res_st, n_res_st;
    logic                r_ovalid, n_ovalid;
    logic [31:0]         r_oarr, n_oarr;
    erss_pkg::t_status   r_ost, n_ost;

    logic                link_we;
    logic [LW-1:0]       link_raddr;
    logic [LinkW-1:0]    link_rdata;
    logic                lab_we;
    logic [PW-1:0]       lab_waddr, lab_raddr;
    logic [31:0]         lab_wdata, lab_rdata;

    logic                in_acc;
    logic                bad_port;
    logic [PW-1:0]       src_i, dst_i, lk_s, lk_d;
    logic [31:0]         lk_dep, lk_arr;
    logic                improve;

    erss_ram #(.Width(LinkW), .Depth(MAX_LINKS)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (r_count[LW-1:0]),
        .i_wdata ({i_source_port, i_dest_port, i_depart_time, i_arrive_time}),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    erss_ram #(.Width(32), .Depth(NumPorts)) u_label_ram (
        .i_clk   (i_clk),
        .i_we    (lab_we),
        .i_waddr (lab_waddr),
        .i_wdata (lab_wdata),
        .i_raddr (lab_raddr),
        .o_rdata (lab_rdata)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign bad_port   = (32'(i_source_port) >= 32'(MAX_PORTS)) ||
                        (32'(i_dest_port) >= 32'(MAX_PORTS));
    assign src_i      = i_source_port[PW-1:0];
    assign dst_i      = i_dest_port[PW-1:0];
    assign lk_s       = link_rdata[LinkW-8 +: PW];
    assign lk_d       = link_rdata[2*erss_pkg::TimeW +: PW];
    assign lk_dep     = link_rdata[erss_pkg::TimeW +: 32];
    assign lk_arr     = link_rdata[31:0];
    assign improve    = r_use && (!r_lvalid[lk_d] || (lab_rdata > lk_arr));

    // sequence adds and relaxation passes
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_changed = r_changed;
        n_use     = r_use;
        n_known   = r_known;
        n_lvalid  = r_lvalid;
        n_qdst    = r_qdst;
        n_res_arr = r_res_arr;
        n_res_st  = r_res_st;
        n_ovalid  = r_ovalid;
        n_oarr    = r_oarr;
        n_ost     = r_ost;
        link_we   = 1'b0;
        link_raddr = r_idx[LW-1:0];
        lab_we    = 1'b0;
        lab_waddr = lk_d;
        lab_wdata = lk_arr;
        lab_raddr = lk_s;

        // drop the output beat once taken
        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_res_arr = 32'd0;
                    n_state   = S_DONE;
                    n_qdst    = dst_i;
                    if (bad_port) begin
                        n_res_st = erss_pkg::ST_UNKNOWN;
                    end else if (i_command == erss_pkg::CMD_ADD) begin
                        if (32'(r_count) >= 32'(MAX_LINKS)) begin
                            n_res_st = erss_pkg::ST_FULL;
                        end else begin
                            link_we        = 1'b1;
                            n_count        = r_count + 1'b1;
                            n_known[src_i] = 1'b1;
                            n_known[dst_i] = 1'b1;
                            n_res_st       = erss_pkg::ST_STORED;
                        end
                    end else if (!r_known[src_i] || !r_known[dst_i]) begin
                        n_res_st = erss_pkg::ST_UNKNOWN;
                    end else begin
                        // seed the start port label
                        n_lvalid        = '0;
                        n_lvalid[src_i] = 1'b1;
                        lab_we          = 1'b1;
                        lab_waddr       = src_i;
                        lab_wdata       = i_start_time;
                        n_idx           = '0;
                        n_changed       = 1'b0;
                        n_state         = (r_count == '0) ? S_FIN : S_RL;
                    end
                end
            end
            S_RL: begin
                n_state = S_LS;
            end
            S_LS: begin
                lab_raddr = lk_s;
                n_state   = S_LD;
            end
            S_LD: begin
                n_use     = r_lvalid[lk_s] && (lk_dep >= lab_rdata);
                lab_raddr = lk_d;
                n_state   = S_UP;
            end
            S_UP: begin
                if (improve) begin
                    lab_we           = 1'b1;
                    n_lvalid[lk_d]   = 1'b1;
                end
                if (r_idx + 1'b1 == r_count) begin
                    n_idx = '0;
                    if (r_changed || improve) begin
                        n_changed = 1'b0;
                        n_state   = S_RL;
                    end else begin
                        n_state = S_FIN;
                    end
                end else begin
                    n_idx     = r_idx + 1'b1;
                    n_changed = r_changed || improve;
                    n_state   = S_RL;
                end
            end
            S_FIN: begin
                lab_raddr = r_qdst;
                n_state   = S_RES;
            end
            S_RES: begin
                if (r_lvalid[r_qdst]) begin
                    n_res_arr = lab_rdata;
                    n_res_st  = erss_pkg::ST_FOUND;
                end else begin
                    n_res_arr = 32'd0;
                    n_res_st  = erss_pkg::ST_NOROUTE;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_ovalid || i_out_ready) begin
                    n_ovalid = 1'b1;
                    n_oarr   = r_res_arr;
                    n_ost    = r_res_st;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_known  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_known  <= n_known;
            r_ovalid <= n_ovalid;
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_changed <= n_changed;
        r_use     <= n_use;
        r_lvalid  <= n_lvalid;
        r_qdst    <= n_qdst;
        r_res_arr <= n_res_arr;
        r_res_st  <= n_res_st;
        r_oarr    <= n_oarr;
        r_ost     <= n_ost;
    end

    assign o_out_valid    = r_ovalid;
    assign o_arrival_time = r_oarr;
    assign o_status       = r_ost;

    // check sequencing
    a_acc_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != S_IDLE))
        else $error("accepted beat did not start work");
    a_up_after_ld: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UP) |-> ($past(r_state) == S_LD))
        else $error("label update without source read");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= 32'(MAX_LINKS))
        else $error("link count overflow");
    a_found_only_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RES) |=> (r_res_st == erss_pkg::ST_FOUND ||
                                r_res_st == erss_pkg::ST_NOROUTE))
        else $error("bad query status");
endmodule
